// ===== rtl/oqp_pkg.sv =====
// Package with the shared constants and types of the ordered queue with ID pool.
package oqp_pkg;

  localparam int NUM_IDS = 1024;
  localparam int ID_W    = $clog2(NUM_IDS);
  localparam int CNT_W   = $clog2(NUM_IDS + 1);

  typedef enum logic [1:0] {
    REQ_GIVE = 2'd0,
    REQ_SEAT = 2'd1,
    REQ_KICK = 2'd2,
    REQ_MOVE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EX1,
    ST_EX2,
    ST_EX3,
    ST_DONE
  } state_e;

  // Word of the previous-link memory: membership flag and previous ID.
  typedef struct packed {
    logic            inq;
    logic [ID_W-1:0] prev;
  } pq_t;

endpackage

// ===== rtl/ordered_queue_with_id_pool_unit.sv =====
// Top level: ordered ID queue held as linked lists in two link memories.
// Each item passes idle, EX1, EX2 (a granted give to a non-empty queue, a kick out or a move
// to front of a queued ID, the move only if not at the head), EX3 (that move only) and DONE,
// waiting for the output register; one item is worked on at a time, the steps set by the
// dependent writes to the single write port of each link memory. After reset it sweeps the
// previous-link memory, one entry a cycle, clearing NUM_IDS (1024) flags, accepting no item.
module ordered_queue_with_id_pool_unit
  import oqp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  buzzer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  id_out_o,
  output logic        ok_o,
  output logic [10:0] queue_length_o
);

  state_e state_q, state_d;
  req_e   req_q, req_d;
  logic [ID_W-1:0]  clr_q, clr_d;
  logic [ID_W-1:0]  head_q, head_d, tail_q, tail_d, ftop_q, ftop_d;
  logic             fempty_q, fempty_d;
  logic [CNT_W-1:0] count_q, count_d, fresh_q, fresh_d;
  logic [ID_W-1:0]  id_q, id_d, p_q, p_d;
  logic             ok_q, ok_d;
  logic             ovalid_q, ovalid_d;
  logic [9:0]       oid_q, oid_d;
  logic             ook_q, ook_d;
  logic [10:0]      olen_q, olen_d;

  logic            nx_we, pq_we;
  logic [ID_W-1:0] nx_waddr, pq_waddr, nx_raddr, nx_rdata;
  logic [ID_W-1:0] nx_wdata;
  pq_t             pq_wdata, pq_rdata;
  logic            in_acc;
  logic [ID_W-1:0] gid;
  logic [CNT_W-1:0] cnt_inc, fresh_inc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Next-link memory, also threads the free list.
  oqp_ram #(.Width(ID_W), .Depth(NUM_IDS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (nx_raddr),
    .rdata_o (nx_rdata)
  );

  // Previous-link memory with the membership flag.
  oqp_ram #(.Width(ID_W + 1), .Depth(NUM_IDS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pq_we),
    .waddr_i (pq_waddr),
    .wdata_i (pq_wdata),
    .raddr_i (ID_W'(buzzer_i)),
    .rdata_o (pq_rdata)
  );

  // Read address of the next-link memory, used in the accept cycle.
  always_comb begin
    unique case (req_e'(req_type_i))
      REQ_GIVE: nx_raddr = ftop_q;
      REQ_SEAT: nx_raddr = head_q;
      default:  nx_raddr = ID_W'(buzzer_i);
    endcase
  end

  // Sequencer: next state, memory writes and register updates.
  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    clr_d    = clr_q;
    head_d   = head_q;
    tail_d   = tail_q;
    ftop_d   = ftop_q;
    fempty_d = fempty_q;
    count_d  = count_q;
    fresh_d  = fresh_q;
    id_d     = id_q;
    p_d      = p_q;
    ok_d     = ok_q;
    ovalid_d = ovalid_q && out_stall_i;
    oid_d    = oid_q;
    ook_d    = ook_q;
    olen_d   = olen_q;
    nx_we    = 1'b0;
    nx_waddr = id_q;
    nx_wdata = '0;
    pq_we    = 1'b0;
    pq_waddr = id_q;
    pq_wdata = '0;
    in_stall_o = 1'b1;
    gid       = fempty_q ? fresh_q[ID_W-1:0] : ftop_q;
    cnt_inc   = count_q + CNT_W'(1);
    fresh_inc = fempty_q ? fresh_q + CNT_W'(1) : fresh_q;

    unique case (state_q)
      ST_CLEAR: begin
        pq_we    = 1'b1;
        pq_waddr = clr_q;
        clr_d    = clr_q + ID_W'(1);
        if (clr_q == ID_W'(NUM_IDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d   = req_e'(req_type_i);
          id_d    = ID_W'(buzzer_i);
          state_d = ST_EX1;
        end
      end
      ST_EX1: begin
        state_d = ST_DONE;
        unique case (req_q)
          REQ_GIVE: begin
            ok_d = 1'b0;
            id_d = '0;
            if (!fempty_q || fresh_q < CNT_W'(NUM_IDS)) begin
              ok_d          = 1'b1;
              id_d          = gid;
              p_d           = tail_q;
              nx_we         = 1'b1;
              nx_waddr      = gid;
              nx_wdata      = '0;
              pq_we         = 1'b1;
              pq_waddr      = gid;
              pq_wdata.inq  = 1'b1;
              pq_wdata.prev = (count_q == '0) ? '0 : tail_q;
              if (count_q == '0) begin
                head_d = gid;
              end else begin
                state_d = ST_EX2;
              end
              if (!fempty_q) begin
                ftop_d = nx_rdata;
              end
              tail_d   = gid;
              count_d  = cnt_inc;
              fresh_d  = fresh_inc;
              fempty_d = (fresh_inc == cnt_inc);
            end
          end
          REQ_SEAT: begin
            ok_d = 1'b0;
            id_d = '0;
            if (count_q != '0) begin
              ok_d     = 1'b1;
              id_d     = head_q;
              head_d   = nx_rdata;
              nx_we    = 1'b1;
              nx_waddr = head_q;
              nx_wdata = fempty_q ? '0 : ftop_q;
              pq_we    = 1'b1;
              pq_waddr = head_q;
              ftop_d   = head_q;
              fempty_d = 1'b0;
              count_d  = count_q - CNT_W'(1);
            end
          end
          default: begin
            ok_d = pq_rdata.inq;
            p_d  = pq_rdata.prev;
            if (pq_rdata.inq && !(req_q == REQ_MOVE && id_q == head_q)) begin
              state_d = ST_EX2;
              // Unlink the target from its neighbors.
              if (id_q == head_q) begin
                head_d = nx_rdata;
              end else begin
                nx_we    = 1'b1;
                nx_waddr = pq_rdata.prev;
                nx_wdata = nx_rdata;
              end
              if (id_q == tail_q) begin
                tail_d = pq_rdata.prev;
              end else begin
                pq_we         = 1'b1;
                pq_waddr      = nx_rdata;
                pq_wdata.inq  = 1'b1;
                pq_wdata.prev = pq_rdata.prev;
              end
            end
          end
        endcase
      end
      ST_EX2: begin
        state_d = ST_DONE;
        unique case (req_q)
          REQ_GIVE: begin
            nx_we    = 1'b1;
            nx_waddr = p_q;
            nx_wdata = id_q;
          end
          REQ_KICK: begin
            nx_we    = 1'b1;
            nx_wdata = fempty_q ? '0 : ftop_q;
            pq_we    = 1'b1;
            ftop_d   = id_q;
            fempty_d = 1'b0;
            count_d  = count_q - CNT_W'(1);
          end
          REQ_MOVE: begin
            nx_we        = 1'b1;
            nx_wdata     = head_q;
            pq_we        = 1'b1;
            pq_wdata.inq = 1'b1;
            state_d      = ST_EX3;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_EX3: begin
        pq_we         = 1'b1;
        pq_waddr      = head_q;
        pq_wdata.inq  = 1'b1;
        pq_wdata.prev = id_q;
        head_d        = id_q;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          oid_d    = 10'(id_q);
          ook_d    = ok_q;
          olen_d   = 11'(count_q);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      ftop_q   <= '0;
      fempty_q <= 1'b1;
      count_q  <= '0;
      fresh_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      ftop_q   <= ftop_d;
      fempty_q <= fempty_d;
      count_q  <= count_d;
      fresh_q  <= fresh_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    id_q   <= id_d;
    p_q    <= p_d;
    ok_q   <= ok_d;
    oid_q  <= oid_d;
    ook_q  <= ook_d;
    olen_q <= olen_d;
  end

  assign out_valid_o    = ovalid_q;
  assign id_out_o       = oid_q;
  assign ok_o           = ook_q;
  assign queue_length_o = olen_q;

  // The queue never holds more IDs than were ever handed out.
  a_count_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fresh_q) else $error("queue length exceeds IDs handed out");

  // An empty free list means every handed-out ID is queued.
  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fempty_q |-> (count_q == fresh_q)) else $error("free list state inconsistent");

  // An accepted item starts work in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_EX1)) else $error("accepted item not started");

  // Only a move to front takes the third step.
  a_ex3_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EX3) |-> (req_q == REQ_MOVE))
    else $error("third step outside move to front");

endmodule

// ===== rtl/oqp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module oqp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
